[rtl/core/vlma_pkg.sv]
package vlma_pkg;

  // History depth, in samples
  localparam int unsigned DEPTH    = 64;
  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 7;
  // Cell index width and window sum width
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned SUM_W    = SAMPLE_W + IDX_W;

  // Divider request: a start pulse with the window sum and the length
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [LEN_W-1:0]        len;
  } div_req_t;

  // Divider response: busy flag, one-cycle done pulse, held quotient
  typedef struct packed {
    logic                       busy;
    logic                       done;
    logic signed [SAMPLE_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/variable_length_moving_average.sv]
// Variable-length moving average over the newest samples.
// Input stream s_axis_*: one signed 16-bit sample per beat. Output stream
// m_axis_*: one signed 16-bit mean per input beat, in order. The mean covers
// the newest window_length samples, current one included, truncated toward
// zero; a length of zero acts as 1 and one above the history depth as the depth.
// cfg_wen_i/cfg_wdata_i write window_length; write it only while idle.
// Samples sit in a row of cells that shift on every input beat. A read token
// walks down the row to pick out the sample leaving the window, or to rebuild
// the window sum one cell per cycle after the length has changed.
// A new sample is taken only after the mean of the last one is done. After a
// length change the window sum is first rebuilt over the effective length.
// The serial divider forms the mean, making one quotient bit per cycle
// over the 22-bit sum. The output register holds a finished mean while the
// receiver stalls; the next sample is taken meanwhile, and the block waits
// only when a second mean is ready before the first was taken.
// Reset clears the history to zero, the window length to 1 and the output
// register's valid flag; no clearing pass is needed.
module variable_length_moving_average (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration: window_length
  input  logic                    cfg_wen_i,
  input  logic [6:0]              cfg_wdata_i,
  // Input stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [15:0]             s_axis_tdata,   // [15:0] sample
  // Output stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [15:0]             m_axis_tdata    // [15:0] average
);
  import vlma_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SUM   = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [LEN_W-1:0]        wl_q;
  logic [LEN_W-1:0]        len_eff;
  logic [LEN_W-1:0]        len_q, len_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [IDX_W-1:0]        cnt_q, cnt_d;
  logic                    out_vld_q, out_vld_d;
  logic [SAMPLE_W-1:0]     out_data_q, out_data_d;
  logic                    pend_q, pend_d;
  logic [SAMPLE_W-1:0]     pend_data_q, pend_data_d;

  logic                       in_beat;
  logic                       recompute;
  logic                       sum_last;
  logic                       tok_load;
  logic                       tok_adv;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic signed [SAMPLE_W-1:0] tap;
  logic signed [SAMPLE_W-1:0] samp_w [DEPTH];
  logic signed [SAMPLE_W-1:0] tap_w  [DEPTH];
  logic [DEPTH-1:0]           tok_w;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= LEN_W'(1);
    end else if (cfg_wen_i) begin
      wl_q <= cfg_wdata_i;
    end
  end

  // Effective length: zero acts as 1, clipped to the history depth
  always_comb begin
    if (wl_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(wl_q) > DEPTH) begin
      len_eff = LEN_W'(DEPTH);
    end else begin
      len_eff = wl_q;
    end
  end

  assign sample_in     = $signed(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE) && !pend_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign recompute     = (len_eff != len_q);
  assign tok_load      = in_beat && recompute;
  // The token stops on the oldest window cell, the one that leaves next
  assign sum_last      = ((32'(cnt_q) + 32'd1) == 32'(len_q));
  assign tok_adv       = (state_q == ST_SUM) && !sum_last;

  // Row of sample cells; the token starts at the head on a rebuild
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      vlma_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (in_beat),
        .sample_i   (sample_in),
        .sample_o   (samp_w[k]),
        .tok_load_i (tok_load),
        .tok_set_i  (1'b1),
        .tok_adv_i  (tok_adv),
        .tok_i      (1'b0),
        .tok_o      (tok_w[k]),
        .tap_o      (tap_w[k])
      );
    end else begin : g_body
      vlma_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (in_beat),
        .sample_i   (samp_w[k-1]),
        .sample_o   (samp_w[k]),
        .tok_load_i (tok_load),
        .tok_set_i  (1'b0),
        .tok_adv_i  (tok_adv),
        .tok_i      (tok_w[k-1]),
        .tok_o      (tok_w[k]),
        .tap_o      (tap_w[k])
      );
    end
  end

  // Shared tap: at most one cell drives a nonzero value
  always_comb begin
    tap = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap = tap | tap_w[i];
    end
  end

  assign div_req.start = (state_q == ST_START);
  assign div_req.sum   = sum_q;
  assign div_req.len   = len_q;

  vlma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer, window sum and output staging
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    out_vld_d   = out_vld_q;
    out_data_d  = out_data_q;
    pend_d      = pend_q;
    pend_data_d = pend_data_q;

    // Output register drains, then refills from the pending slot
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (pend_q && !out_vld_d) begin
      out_vld_d  = 1'b1;
      out_data_d = pend_data_q;
      pend_d     = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          len_d = len_eff;
          if (recompute) begin
            sum_d   = '0;
            cnt_d   = '0;
            state_d = ST_SUM;
          end else begin
            // Token sits on the sample that leaves the window
            sum_d   = sum_q + SUM_W'(sample_in) - SUM_W'(tap);
            state_d = ST_START;
          end
        end
      end
      ST_SUM: begin
        sum_d = sum_q + SUM_W'(tap);
        cnt_d = cnt_q + IDX_W'(1);
        if (sum_last) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_IDLE;
          if (!out_vld_d) begin
            out_vld_d  = 1'b1;
            out_data_d = div_rsp.quotient;
          end else begin
            pend_d      = 1'b1;
            pend_data_d = div_rsp.quotient;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    pend_data_q <= pend_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // The read token never sits in two cells at once
  a_tok_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_w))
    else $error("read token duplicated in the cell row");

  // During a rebuild exactly one cell is being read
  a_sum_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> $onehot(tok_w))
    else $error("window rebuild without a read token");

  // The divider is never restarted while it is working
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Any item in flight has a valid window length
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (len_q != '0) && (32'(len_q) <= DEPTH))
    else $error("window length out of range during processing");

endmodule

[rtl/core/vlma_cell.sv]
module vlma_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic signed [vlma_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [vlma_pkg::SAMPLE_W-1:0] sample_o,
  input  logic                                 tok_load_i,
  input  logic                                 tok_set_i,
  input  logic                                 tok_adv_i,
  input  logic                                 tok_i,
  output logic                                 tok_o,
  output logic signed [vlma_pkg::SAMPLE_W-1:0] tap_o
);
  import vlma_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       tok_q;

  // Sample slot: takes the neighbor's sample on each new beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  // Read token: set at the row head on load; moves one cell a cycle on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (tok_load_i) begin
      tok_q <= tok_set_i;
    end else if (tok_adv_i) begin
      tok_q <= tok_i;
    end
  end

  assign sample_o = sample_q;
  assign tok_o    = tok_q;
  // Only the cell holding the token drives the shared tap
  assign tap_o    = tok_q ? sample_q : '0;

endmodule

[rtl/core/vlma_div.sv]
module vlma_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vlma_pkg::div_req_t req_i,
  output vlma_pkg::div_rsp_t rsp_o
);
  import vlma_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0] sum_u;
  logic [SUM_W-1:0] mag;
  logic [LEN_W:0]   rem_sh;
  logic             q_bit;
  logic [LEN_W-1:0] rem_nxt;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [LEN_W-1:0] div_q;
  logic [LEN_W-1:0] rem_q;
  logic [SUM_W-1:0] quo_q;
  logic [SAMPLE_W-1:0] quo_lo;

  // Sign and magnitude of the dividend
  assign sum_u = req_i.sum;
  assign mag   = sum_u[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, quo_q[SUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, div_q});
    rem_nxt = q_bit ? LEN_W'(rem_sh - {1'b0, div_q}) : rem_sh[LEN_W-1:0];
  end

  // Control: one quotient bit per cycle while busy, then a done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= sum_u[SUM_W-1];
      div_q <= req_i.len;
      rem_q <= '0;
      quo_q <= mag;
    end else if (busy_q) begin
      rem_q <= rem_nxt;
      quo_q <= {quo_q[SUM_W-2:0], q_bit};
    end
  end

  // Truncation toward zero: restore the sign on the magnitude quotient
  assign quo_lo         = quo_q[SAMPLE_W-1:0];
  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? $signed(~quo_lo + SAMPLE_W'(1)) : $signed(quo_lo);

endmodule
